// ===== rtl/core/ose_pkg.sv =====
package ose_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;

    // Operation codes carried by the op field.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_DUMP = 3'd1,
        OP_PEEK = 3'd2,
        OP_POP  = 3'd3,
        OP_SWAP = 3'd4
    } op_e;

    // Status codes returned with each result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_PEEK_EMPTY = 3'd1,
        ST_POP_EMPTY  = 3'd2,
        ST_SWAP_SHORT = 3'd3,
        ST_PUSH_FULL  = 3'd4
    } status_e;

    // Which address the stack memory reads.
    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_PTR_NEXT
    } rd_sel_e;

    // Which address and data the stack memory writes.
    typedef enum logic [1:0] {
        WR_PUSH,
        WR_TOP_RDATA,
        WR_SECOND_HOLD
    } wr_sel_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    rd_en;
        rd_sel_e rd_sel;
        logic    wr_en;
        wr_sel_e wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    ptr_load;
        logic    ptr_dec;
        logic    hold_load;
        logic    out_load;
        logic    out_from_ram;
        status_e out_status;
        logic    out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic below_two;
        logic full;
        logic ptr_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/ose_ram.sv =====
module ose_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ose_dp.sv =====
module ose_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ose_pkg::DATA_W-1:0]    push_value,
    input  ose_pkg::dp_cmd_t              dp_cmd,
    output ose_pkg::dp_stat_t             dp_stat,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [ose_pkg::DATA_W-1:0]    data_value,
    output logic [ose_pkg::STATUS_W-1:0]  status,
    output logic                          last
);
    import ose_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [DATA_W-1:0] hold_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    status_e           out_status_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] second_addr;
    logic [ADDR_W-1:0] ptr_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;

    // Addresses of the top two entries and the next dump entry.
    assign cnt_m1      = cnt_reg - CNT_W'(1);
    assign cnt_m2      = cnt_reg - CNT_W'(2);
    assign top_addr    = cnt_m1[ADDR_W-1:0];
    assign second_addr = cnt_m2[ADDR_W-1:0];
    assign ptr_m1      = ptr_reg - ADDR_W'(1);

    // Read address selection.
    always_comb
    begin
        unique case (dp_cmd.rd_sel)
            RD_TOP:      rd_addr = top_addr;
            RD_SECOND:   rd_addr = second_addr;
            RD_PTR_NEXT: rd_addr = ptr_m1;
            default:     rd_addr = top_addr;
        endcase
    end

    // Write address and data selection.
    always_comb
    begin
        unique case (dp_cmd.wr_sel)
            WR_PUSH:
            begin
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = push_value;
            end
            WR_TOP_RDATA:
            begin
                wr_addr = top_addr;
                wr_data = rd_data;
            end
            WR_SECOND_HOLD:
            begin
                wr_addr = second_addr;
                wr_data = hold_reg;
            end
            default:
            begin
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = push_value;
            end
        endcase
    end

    ose_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (dp_cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (dp_cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Entry count and dump pointer next values.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (dp_cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (dp_cmd.cnt_dec)
        begin
            cnt_next = cnt_m1;
        end

        ptr_next = ptr_reg;
        if (dp_cmd.ptr_load)
        begin
            ptr_next = top_addr;
        end
        else if (dp_cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
    end

    assign out_free = !out_valid_reg || rsp_ready;

    // Control registers: entry count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (dp_cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: pointer, swap holding register and result.
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (dp_cmd.hold_load)
        begin
            hold_reg <= rd_data;
        end
        if (dp_cmd.out_load)
        begin
            out_data_reg   <= dp_cmd.out_from_ram ? rd_data : '0;
            out_status_reg <= dp_cmd.out_status;
            out_last_reg   <= dp_cmd.out_last;
        end
    end

    assign dp_stat.empty     = (cnt_reg == '0);
    assign dp_stat.below_two = (cnt_reg < CNT_W'(2));
    assign dp_stat.full      = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign dp_stat.ptr_zero  = (ptr_reg == '0);
    assign dp_stat.out_free  = out_free;

    assign rsp_valid  = out_valid_reg;
    assign data_value = out_data_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    // The count never passes the stack depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // The count never grows and shrinks in the same cycle.
    a_cnt_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.cnt_inc && dp_cmd.cnt_dec))
        else $error("count increment and decrement together");

    // A push writes only into a stack that has room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.wr_en && dp_cmd.wr_sel == WR_PUSH) |-> !dp_stat.full)
        else $error("push write into a full stack");

endmodule

// ===== rtl/core/ose_ctrl.sv =====
module ose_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [ose_pkg::OP_W-1:0]    op,
    input  ose_pkg::dp_stat_t           dp_stat,
    output ose_pkg::dp_cmd_t            dp_cmd
);
    import ose_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_PEEK,
        S_DUMP,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C
    } state_t;

    state_t  state_reg, state_next;
    status_e resp_status_reg, resp_status_next;
    logic    accept;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next          = state_reg;
        resp_status_next    = resp_status_reg;
        dp_cmd              = '0;
        dp_cmd.rd_sel       = RD_TOP;
        dp_cmd.wr_sel       = WR_PUSH;
        dp_cmd.out_status   = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_e'(op))
                        OP_PUSH:
                        begin
                            state_next = S_RESP;
                            if (dp_stat.full)
                            begin
                                resp_status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                resp_status_next = ST_OK;
                                dp_cmd.wr_en     = 1'b1;
                                dp_cmd.wr_sel    = WR_PUSH;
                                dp_cmd.cnt_inc   = 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            // An empty stack gives no result at all.
                            if (!dp_stat.empty)
                            begin
                                dp_cmd.ptr_load = 1'b1;
                                dp_cmd.rd_en    = 1'b1;
                                dp_cmd.rd_sel   = RD_TOP;
                                state_next      = S_DUMP;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (dp_stat.empty)
                            begin
                                resp_status_next = ST_PEEK_EMPTY;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.rd_en  = 1'b1;
                                dp_cmd.rd_sel = RD_TOP;
                                state_next    = S_PEEK;
                            end
                        end
                        OP_POP:
                        begin
                            state_next = S_RESP;
                            if (dp_stat.empty)
                            begin
                                resp_status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                resp_status_next = ST_OK;
                                dp_cmd.cnt_dec   = 1'b1;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (dp_stat.below_two)
                            begin
                                resp_status_next = ST_SWAP_SHORT;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.rd_en  = 1'b1;
                                dp_cmd.rd_sel = RD_TOP;
                                state_next    = S_SWAP_A;
                            end
                        end
                        default:
                        begin
                            // Unknown operations are dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.out_load   = 1'b1;
                    dp_cmd.out_status = resp_status_reg;
                    dp_cmd.out_last   = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_PEEK:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.out_load     = 1'b1;
                    dp_cmd.out_from_ram = 1'b1;
                    dp_cmd.out_last     = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // Each transfer of an entry launches the read of the one below.
                if (dp_stat.out_free)
                begin
                    dp_cmd.out_load     = 1'b1;
                    dp_cmd.out_from_ram = 1'b1;
                    dp_cmd.out_last     = dp_stat.ptr_zero;
                    if (dp_stat.ptr_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dp_cmd.rd_en   = 1'b1;
                        dp_cmd.rd_sel  = RD_PTR_NEXT;
                        dp_cmd.ptr_dec = 1'b1;
                    end
                end
            end
            S_SWAP_A:
            begin
                dp_cmd.hold_load = 1'b1;
                dp_cmd.rd_en     = 1'b1;
                dp_cmd.rd_sel    = RD_SECOND;
                state_next       = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                dp_cmd.wr_en  = 1'b1;
                dp_cmd.wr_sel = WR_TOP_RDATA;
                state_next    = S_SWAP_C;
            end
            S_SWAP_C:
            begin
                dp_cmd.wr_en     = 1'b1;
                dp_cmd.wr_sel    = WR_SECOND_HOLD;
                resp_status_next = ST_OK;
                state_next       = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the pending status of a single-result operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            resp_status_reg <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
        end
    end

endmodule

// ===== rtl/core/operand_stack_engine_top.sv =====
// Operand stack engine: a LIFO of up to 64 signed 32-bit entries held in a
// single-port-read memory. Each transfer on the cmd channel carries one
// operation (push, dump, peek, pop, swap); push, pop, swap and peek answer with
// one result, dump answers with one result per entry from top to bottom and the
// last one flagged, and a dump of an empty stack or an unknown op gives nothing.
// From the command transfer to the result being valid: push, pop and the error
// cases pass through S_RESP and peek through S_PEEK before the result register
// loads; swap passes through S_SWAP_A, S_SWAP_B, S_SWAP_C and then S_RESP, since
// the one memory read port fetches the two entries in turn before two writes;
// a dump stays in S_DUMP, giving one entry per cycle while rsp_ready is high.
// One operation is handled at a time; cmd_ready is high while no operation is
// in progress, which includes the time a finished result waits to be taken.
module operand_stack_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [ose_pkg::OP_W-1:0]      op,
    input  logic signed [ose_pkg::DATA_W-1:0] push_value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic signed [ose_pkg::DATA_W-1:0] data_value,
    output logic [ose_pkg::STATUS_W-1:0]  status,
    output logic                          last
);
    import ose_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Operation sequencing.
    ose_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .op        (op),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Stack memory, count, pointer and result register.
    ose_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (push_value),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .rsp_ready  (rsp_ready),
        .rsp_valid  (rsp_valid),
        .data_value (data_value),
        .status     (status),
        .last       (last)
    );

endmodule
